// ===== hdl/rtt_pkg.sv =====
// Shared constants, types and helper functions of the RSI threshold trader.
package rtt_pkg;

  // Ring depth and the number of price bits in use.
  localparam int MAX_WINDOW = 64;
  localparam int PRICE_BITS = 32;

  // Fixed field widths of the ports and registers.
  localparam int IN_W       = 32;
  localparam int WLEN_W     = 7;
  localparam int POS_W      = 10;
  localparam int LVL_W      = 15;
  localparam int HELD_W     = POS_W + 1;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int ACT_W      = 2;
  localparam int CASH_W     = 64;

  // Derived widths.
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
  localparam int LV_W   = $clog2(2 * MAX_WINDOW + 1);
  localparam int SUM_W  = PRICE_BITS + PTR_W + 1;
  localparam int PROD_W = SUM_W + LVL_W;
  localparam int MP_W   = HELD_W + PRICE_BITS + 1;

  // RSI of 100 percent in units of 1/256 percent.
  localparam int RSI_SCALE = 25600;

  // Queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register values after reset.
  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(14);
  localparam logic [POS_W-1:0]  MAXPOS_RESET = POS_W'(1);
  localparam logic [LVL_W-1:0]  OVERSOLD_RESET = LVL_W'(7680);
  localparam logic [LVL_W-1:0]  OVERBOUGHT_RESET = LVL_W'(17920);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_MAX_POSITION  = 2'd1,
    REG_OVERSOLD      = 2'd2,
    REG_OVERBOUGHT    = 2'd3
  } cfg_reg_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  // One price difference as held in the ring: sign class and magnitude.
  typedef struct packed {
    logic                  is_gain;
    logic [PRICE_BITS-1:0] mag;
  } diff_t;

  // One classified item as handed from the front to the back.
  typedef struct packed {
    logic [PRICE_BITS-1:0] close;
    diff_t                 diff;
    logic                  has_diff;
    logic                  full;
    logic                  bypass;
    logic [PTR_W-1:0]      wr_addr;
    logic [PTR_W-1:0]      rd_addr;
  } item_t;

  // Trading limits used by the back part.
  typedef struct packed {
    logic [POS_W-1:0] max_pos;
    logic [LVL_W-1:0] oversold;
    logic [LVL_W-1:0] overbought;
  } trade_cfg_t;

  // Clamps a sum that is one bit wider than the cash width.
  function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_W:0] s);
    logic signed [CASH_W-1:0] r;
    if (s[CASH_W] != s[CASH_W-1]) begin
      r = s[CASH_W] ? {1'b1, {(CASH_W-1){1'b0}}} : {1'b0, {(CASH_W-1){1'b1}}};
    end else begin
      r = s[CASH_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/rtt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rtt_front.sv =====
// Front part: takes close prices, forms differences and ring addresses.
module rtt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [rtt_pkg::WLEN_W-1:0]   wlen,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rtt_pkg::IN_W-1:0]     in_close_price,
  input  logic                         q_full,
  output logic                         push,
  output rtt_pkg::item_t               push_item
);
  import rtt_pkg::*;

  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]      items_seen_r, items_seen_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;

  logic [CNT_W-1:0]      len_eff;
  logic [PRICE_BITS-1:0] close;
  logic                  has_diff;
  logic [LV_W-1:0]       leave_raw;
  logic [LV_W-1:0]       leave_wrap;

  always_comb begin
    // A window length of zero acts as one, and lengths past the ring depth are clamped.
    if (wlen == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(wlen) > MAX_WINDOW) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = CNT_W'(wlen);
    end

    close    = PRICE_BITS'(in_close_price);
    has_diff = (items_seen_r != '0);

    // Entry that drops out of the window once this difference is in.
    leave_raw  = LV_W'(ptr_r) + LV_W'(MAX_WINDOW + 1) - LV_W'(len_eff);
    leave_wrap = (leave_raw >= LV_W'(MAX_WINDOW)) ? leave_raw - LV_W'(MAX_WINDOW) : leave_raw;

    push     = in_valid && !q_full;
    in_stall = q_full;

    push_item.close    = close;
    push_item.has_diff = has_diff;
    push_item.full     = has_diff && (items_seen_r >= len_eff);
    push_item.bypass   = (len_eff == CNT_W'(1));
    push_item.wr_addr  = ptr_r;
    push_item.rd_addr  = PTR_W'(leave_wrap);
    if (close > prev_r) begin
      push_item.diff.is_gain = 1'b1;
      push_item.diff.mag     = close - prev_r;
    end else begin
      push_item.diff.is_gain = 1'b0;
      push_item.diff.mag     = prev_r - close;
    end

    prev_nxt       = prev_r;
    items_seen_nxt = items_seen_r;
    ptr_nxt        = ptr_r;
    if (restart) begin
      items_seen_nxt = '0;
      ptr_nxt        = '0;
    end else if (push) begin
      prev_nxt = close;
      if (items_seen_r <= len_eff) begin
        items_seen_nxt = items_seen_r + CNT_W'(1);
      end
      if (has_diff) begin
        ptr_nxt = (ptr_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      items_seen_r <= '0;
      ptr_r        <= '0;
    end else begin
      prev_r       <= prev_nxt;
      items_seen_r <= items_seen_nxt;
      ptr_r        <= ptr_nxt;
    end
  end

`ifndef SYNTHESIS
  // The day count stops one past the window and never runs beyond it.
  assert property (@(posedge clk) disable iff (!rst_n)
    items_seen_r <= len_eff + CNT_W'(1))
    else $error("front day count ran past the window");
`endif

endmodule

// ===== hdl/rtt_queue.sv =====
// Short queue of classified items between the front and back parts.
module rtt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtt_pkg::item_t push_item,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output rtt_pkg::item_t q_item
);
  import rtt_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    q_full  = (count_r == QCNT_W'(QDEPTH));
    q_valid = (count_r != '0);
    q_item  = slot_r[rd_ptr_r];

    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  // The back part only takes an item that is really waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");
`endif

endmodule

// ===== hdl/rtt_back.sv =====
// Back part: window totals, RSI threshold test, trading and valuation pipeline.
module rtt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              restart,
  input  rtt_pkg::trade_cfg_t               cfg,
  input  logic                              q_valid,
  input  rtt_pkg::item_t                    q_item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_window_full,
  output logic [rtt_pkg::ACT_W-1:0]         out_action,
  output logic signed [rtt_pkg::HELD_W-1:0] out_position,
  output logic signed [rtt_pkg::CASH_W-1:0] out_cash_pnl,
  output logic signed [rtt_pkg::CASH_W-1:0] out_mark_to_market
);
  import rtt_pkg::*;

  logic adv;

  // Ring of differences.
  logic [$bits(diff_t)-1:0] ring_rd_data;
  diff_t                    old_diff;

  // Stage 1: item in flight while its leaving entry is read.
  logic  s1_v_r;
  item_t s1_item_r;

  // Stage 2: window totals.
  logic [SUM_W-1:0]      gain_tot_r, gain_tot_nxt;
  logic [SUM_W-1:0]      loss_tot_r, loss_tot_nxt;
  logic [SUM_W-1:0]      gain_in, loss_in, gain_out, loss_out;
  logic [SUM_W-1:0]      g_sum, l_sum;
  logic                  s2_v_r;
  logic                  s2_full_r;
  logic [SUM_W-1:0]      s2_gain_r;
  logic [SUM_W-1:0]      s2_den_r;
  logic [PRICE_BITS-1:0] s2_close_r;

  // Stage 3: cross products against the thresholds.
  logic                  s3_v_r;
  logic                  s3_full_r;
  logic                  s3_den_nz_r;
  logic [PROD_W-1:0]     s3_gain_x_r;
  logic [PROD_W-1:0]     s3_os_x_r;
  logic [PROD_W-1:0]     s3_ob_x_r;
  logic [PRICE_BITS-1:0] s3_close_r;

  // Stage 4: trade decision, position and cash.
  logic signed [HELD_W-1:0] held_r, held_nxt;
  logic signed [CASH_W-1:0] cash_r, cash_nxt;
  logic signed [HELD_W-1:0] max_s, min_s;
  logic signed [CASH_W:0]   close_ext, cash_wide, cash_sum;
  logic                     buy, sell;
  action_t                  s4_act_nxt;
  logic                     s4_v_r;
  logic                     s4_full_r;
  action_t                  s4_act_r;
  logic [PRICE_BITS-1:0]    s4_close_r;

  // Stage 5: position times close.
  logic                     s5_v_r;
  logic                     s5_full_r;
  action_t                  s5_act_r;
  logic signed [HELD_W-1:0] s5_held_r;
  logic signed [CASH_W-1:0] s5_cash_r;
  logic signed [MP_W-1:0]   s5_mtm_x_r;

  // Output register.
  logic                     out_valid_r;
  logic                     out_full_r;
  action_t                  out_action_r;
  logic signed [HELD_W-1:0] out_held_r;
  logic signed [CASH_W-1:0] out_cash_r;
  logic signed [CASH_W-1:0] out_mtm_r;

  // The whole pipeline moves unless the output holds a beat that is not taken.
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && q_valid;

  rtt_ram #(
    .WIDTH($bits(diff_t)),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (pop && q_item.has_diff),
    .wr_addr(q_item.wr_addr),
    .wr_data(q_item.diff),
    .rd_en  (adv),
    .rd_addr(q_item.rd_addr),
    .rd_data(ring_rd_data)
  );

  always_comb begin
    // With a window of one the leaving entry is the one written in the same cycle.
    old_diff = s1_item_r.bypass ? s1_item_r.diff : diff_t'(ring_rd_data);

    gain_in  = (s1_item_r.has_diff && s1_item_r.diff.is_gain) ?
               SUM_W'(s1_item_r.diff.mag) : '0;
    loss_in  = (s1_item_r.has_diff && !s1_item_r.diff.is_gain) ?
               SUM_W'(s1_item_r.diff.mag) : '0;
    gain_out = (s1_item_r.full && old_diff.is_gain) ? SUM_W'(old_diff.mag) : '0;
    loss_out = (s1_item_r.full && !old_diff.is_gain) ? SUM_W'(old_diff.mag) : '0;
    g_sum    = gain_tot_r + gain_in;
    l_sum    = loss_tot_r + loss_in;

    gain_tot_nxt = gain_tot_r;
    loss_tot_nxt = loss_tot_r;
    if (restart) begin
      gain_tot_nxt = '0;
      loss_tot_nxt = '0;
    end else if (adv && s1_v_r) begin
      gain_tot_nxt = g_sum - gain_out;
      loss_tot_nxt = l_sum - loss_out;
    end
  end

  always_comb begin
    max_s     = $signed({1'b0, cfg.max_pos});
    min_s     = -max_s;
    // Buy when RSI is under the oversold level; otherwise sell above overbought.
    buy       = s3_v_r && s3_full_r && s3_den_nz_r &&
                (s3_gain_x_r < s3_os_x_r) && (held_r < max_s);
    sell      = s3_v_r && s3_full_r && s3_den_nz_r && !buy &&
                (s3_gain_x_r > s3_ob_x_r) && (held_r > min_s);
    close_ext = $signed((CASH_W + 1)'(s3_close_r));
    cash_wide = (CASH_W + 1)'(cash_r);
    cash_sum  = buy ? cash_wide - close_ext : cash_wide + close_ext;

    if (buy) begin
      s4_act_nxt = ACT_BUY;
    end else if (sell) begin
      s4_act_nxt = ACT_SELL;
    end else begin
      s4_act_nxt = ACT_NONE;
    end

    held_nxt = held_r;
    cash_nxt = cash_r;
    if (adv && (buy || sell)) begin
      held_nxt = buy ? held_r + HELD_W'(1) : held_r - HELD_W'(1);
      cash_nxt = sat_cash(cash_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_tot_r  <= '0;
      loss_tot_r  <= '0;
      held_r      <= '0;
      cash_r      <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gain_tot_r <= gain_tot_nxt;
      loss_tot_r <= loss_tot_nxt;
      held_r     <= held_nxt;
      cash_r     <= cash_nxt;
      if (adv) begin
        s1_v_r      <= q_valid;
        s2_v_r      <= s1_v_r;
        s3_v_r      <= s2_v_r;
        s4_v_r      <= s3_v_r;
        s5_v_r      <= s4_v_r;
        out_valid_r <= s5_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= q_item;

      s2_full_r  <= s1_item_r.full;
      s2_gain_r  <= g_sum;
      s2_den_r   <= g_sum + l_sum;
      s2_close_r <= s1_item_r.close;

      s3_full_r   <= s2_full_r;
      s3_den_nz_r <= (s2_den_r != '0);
      s3_gain_x_r <= PROD_W'(s2_gain_r) * PROD_W'(RSI_SCALE);
      s3_os_x_r   <= PROD_W'(s2_den_r) * PROD_W'(cfg.oversold);
      s3_ob_x_r   <= PROD_W'(s2_den_r) * PROD_W'(cfg.overbought);
      s3_close_r  <= s2_close_r;

      s4_full_r  <= s3_full_r;
      s4_act_r   <= s4_act_nxt;
      s4_close_r <= s3_close_r;

      // held_r and cash_r carry the values left by the item now in stage 4.
      s5_full_r  <= s4_full_r;
      s5_act_r   <= s4_act_r;
      s5_held_r  <= held_r;
      s5_cash_r  <= cash_r;
      s5_mtm_x_r <= MP_W'(held_r) * $signed(MP_W'(s4_close_r));

      out_full_r   <= s5_full_r;
      out_action_r <= s5_act_r;
      out_held_r   <= s5_held_r;
      out_cash_r   <= s5_cash_r;
      out_mtm_r    <= sat_cash((CASH_W + 1)'(s5_cash_r) + (CASH_W + 1)'(s5_mtm_x_r));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_window_full    = out_full_r;
  assign out_action         = out_action_r;
  assign out_position       = out_held_r;
  assign out_cash_pnl       = out_cash_r;
  assign out_mark_to_market = out_mtm_r;

`ifndef SYNTHESIS
  // A trade is only ever reported on a day with a full window.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_action_r != ACT_NONE) |-> out_full_r)
    else $error("trade reported during warm-up");

  // The position moves by at most one unit from one cycle to the next.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (held_r == $past(held_r)) ||
                     (held_r == $past(held_r) + HELD_W'(1)) ||
                     (held_r == $past(held_r) - HELD_W'(1)))
    else $error("position jumped by more than one unit");
`endif

endmodule

// ===== hdl/rsi_threshold_trader.sv =====
// Top level of the RSI threshold trader: configuration registers and the part wiring.
//
//   Channel | Direction | Handshake          | Beat contents
//   --------+-----------+--------------------+-------------------------------------------
//   in_     | input     | in_valid/in_stall  | close_price
//   out_    | output    | out_valid/out_stall| window_full, action, position, cash_pnl,
//           |           |                    | mark_to_market
//   cfg_    | input     | cfg_valid/cfg_ready| register index and write data
//
// The block takes one input beat per clock while the queue is not full and gives one
// result beat per input beat; each passes through the queue, the back pipeline and
// its output register. The rate is set by two loops: the gain and loss window
// totals in stage two of the back part and the position and cash update in stage four.
// Reset (rst_n low for one clock edge) restores the register defaults and clears all
// counters, totals, position and cash; the difference ring needs no clearing pass.
// out_stall freezes the whole back pipeline; the four-entry queue then fills and
// in_stall rises only when it is full.
module rsi_threshold_trader (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rtt_pkg::IN_W-1:0]              in_close_price,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_window_full,
  output logic [rtt_pkg::ACT_W-1:0]             out_action,
  output logic signed [rtt_pkg::HELD_W-1:0]     out_position,
  output logic signed [rtt_pkg::CASH_W-1:0]     out_cash_pnl,
  output logic signed [rtt_pkg::CASH_W-1:0]     out_mark_to_market,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rtt_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import rtt_pkg::*;

  logic [WLEN_W-1:0] wlen_r, wlen_nxt;
  logic [POS_W-1:0]  max_pos_r, max_pos_nxt;
  logic [LVL_W-1:0]  oversold_r, oversold_nxt;
  logic [LVL_W-1:0]  overbought_r, overbought_nxt;

  logic       cfg_we;
  logic       restart;
  trade_cfg_t trade_cfg;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  // Configuration writes are always taken. Writing the window length restarts
  // warm-up: the front drops its day count and ring pointer, and the back clears
  // its gain and loss totals. Position and cash are kept.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    wlen_nxt       = wlen_r;
    max_pos_nxt    = max_pos_r;
    oversold_nxt   = oversold_r;
    overbought_nxt = overbought_r;
    restart        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH: begin
          wlen_nxt = cfg_data[WLEN_W-1:0];
          restart  = 1'b1;
        end
        REG_MAX_POSITION: begin
          max_pos_nxt = cfg_data[POS_W-1:0];
        end
        REG_OVERSOLD: begin
          oversold_nxt = cfg_data[LVL_W-1:0];
        end
        REG_OVERBOUGHT: begin
          overbought_nxt = cfg_data[LVL_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r       <= WLEN_RESET;
      max_pos_r    <= MAXPOS_RESET;
      oversold_r   <= OVERSOLD_RESET;
      overbought_r <= OVERBOUGHT_RESET;
    end else begin
      wlen_r       <= wlen_nxt;
      max_pos_r    <= max_pos_nxt;
      oversold_r   <= oversold_nxt;
      overbought_r <= overbought_nxt;
    end
  end

  assign trade_cfg.max_pos    = max_pos_r;
  assign trade_cfg.oversold   = oversold_r;
  assign trade_cfg.overbought = overbought_r;

  // The front turns each close into a signed difference, decides whether the
  // window is full, and works out which ring entry falls out of the window.
  rtt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .restart       (restart),
    .wlen          (wlen_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_close_price(in_close_price),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  rtt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // The back keeps the ring and the window totals, compares the index with the
  // thresholds by cross-multiplication, trades and values the position.
  rtt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .restart           (restart),
    .cfg               (trade_cfg),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_full   (out_window_full),
    .out_action        (out_action),
    .out_position      (out_position),
    .out_cash_pnl      (out_cash_pnl),
    .out_mark_to_market(out_mark_to_market)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the RSI threshold trader: scripted and random price beats.
`timescale 1ns / 1ps

module tb_top;
  import rtt_pkg::*;

  // Own copies of the block's fixed sizes, so that the prediction does not lean on
  // the package for anything but port widths and codes.
  localparam int DIFF_SLOTS = 64;
  localparam longint unsigned FULL_SCALE = 25600;
  // Cycles in which no beat moves on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Cycles to wait after the last owed result has come back, to catch stray beats.
  localparam int TAIL_CYCLES = 12;

  // One result beat as the block should report it.
  typedef struct packed {
    logic                     full;
    action_t                  act;
    logic signed [HELD_W-1:0] pos;
    logic signed [CASH_W-1:0] cash;
    logic signed [CASH_W-1:0] mtm;
  } trade_result_t;

  // One line of the scripted opening: either a register write or a price beat. A price
  // beat carries a hand-written result where it is obvious; otherwise the predictor
  // supplies it.
  typedef struct packed {
    logic                  is_write;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] wdata;
    logic [IN_W-1:0]       price;
    logic                  typed;
    trade_result_t         want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [IN_W-1:0]              in_close_price = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_window_full;
  logic [ACT_W-1:0]             out_action;
  logic signed [HELD_W-1:0]     out_position;
  logic signed [CASH_W-1:0]     out_cash_pnl;
  logic signed [CASH_W-1:0]     out_mark_to_market;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int gap_pct = 27;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Results still owed by the block, oldest first.
  trade_result_t expected_days[$];
  script_row_t   directed_script[$];

  // Predictor state: registers, the difference ring, the window totals and the book.
  logic [WLEN_W-1:0] window_reg = 7'd14;
  logic [POS_W-1:0]  max_pos_reg = 10'd1;
  logic [LVL_W-1:0]  oversold_reg = 15'd7680;
  logic [LVL_W-1:0]  overbought_reg = 15'd17920;
  longint            diff_ring [DIFF_SLOTS];
  int unsigned       ring_ptr = 0;
  int unsigned       days_seen = 0;
  longint            prev_close = 0;
  longint unsigned   up_moves = 0;
  longint unsigned   down_moves = 0;
  int                held = 0;
  longint            cash_sum = 0;

  rsi_threshold_trader dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_close_price     (in_close_price),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_full    (out_window_full),
    .out_action         (out_action),
    .out_position       (out_position),
    .out_cash_pnl       (out_cash_pnl),
    .out_mark_to_market (out_mark_to_market),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed 64-bit addition that clamps at both ends of the range instead of wrapping.
  function automatic longint sat_add64(input longint a, input longint b);
    logic [CASH_W:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[CASH_W] != s[CASH_W-1]) begin
      return s[CASH_W] ? {1'b1, {(CASH_W-1){1'b0}}} : {1'b0, {(CASH_W-1){1'b1}}};
    end
    return s[CASH_W-1:0];
  endfunction

  // Advances the trader by one closing price and returns the result it should report.
  // The index is never divided out: gain/(gain+loss) is compared with a threshold by
  // multiplying both sides, gain*25600 against (gain+loss)*level.
  function automatic trade_result_t predict_trade_day(input logic [IN_W-1:0] price);
    trade_result_t r;
    longint cur;
    longint step_diff;
    longint leaving;
    longint unsigned span;
    longint unsigned scaled_gain;
    int unsigned len;
    int unsigned slot;
    cur = price;
    // A length of zero behaves as one, anything past the ring depth as the ring depth.
    if (window_reg == 0) len = 1;
    else if (window_reg > DIFF_SLOTS) len = DIFF_SLOTS;
    else len = window_reg;
    r = '0;
    r.act = ACT_NONE;
    // The first price after reset or a window restart only sets the previous close.
    if (days_seen > 0) begin
      step_diff = cur - prev_close;
      diff_ring[ring_ptr % DIFF_SLOTS] = step_diff;
      if (step_diff > 0) up_moves += step_diff;
      else down_moves += -step_diff;
      if (days_seen >= len) begin
        r.full = 1'b1;
        span = up_moves + down_moves;
        // With no movement at all in the window there is no index and no trade.
        if (span != 0) begin
          scaled_gain = up_moves * FULL_SCALE;
          if (scaled_gain < span * oversold_reg && held < int'(max_pos_reg)) begin
            cash_sum = sat_add64(cash_sum, -cur);
            held++;
            r.act = ACT_BUY;
          end else if (scaled_gain > span * overbought_reg &&
                       held > -int'(max_pos_reg)) begin
            cash_sum = sat_add64(cash_sum, cur);
            held--;
            r.act = ACT_SELL;
          end
        end
        // The oldest difference drops out of the totals after the decision.
        slot = (ring_ptr % DIFF_SLOTS + DIFF_SLOTS - len + 1) % DIFF_SLOTS;
        leaving = diff_ring[slot];
        if (leaving > 0) up_moves -= leaving;
        else down_moves -= -leaving;
      end
      ring_ptr = (ring_ptr + 1) % DIFF_SLOTS;
    end
    if (days_seen <= len) days_seen++;
    prev_close = cur;
    r.pos = HELD_W'(held);
    r.cash = cash_sum;
    r.mtm = sat_add64(cash_sum, longint'(held) * cur);
    return r;
  endfunction

  function automatic script_row_t write_row(input cfg_reg_t sel, input int data);
    script_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.wdata = CFG_DATA_W'(data);
    return r;
  endfunction

  function automatic script_row_t day_row(input logic [IN_W-1:0] price);
    script_row_t r;
    r = '0;
    r.price = price;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [IN_W-1:0] price, input logic full,
                                            input action_t act, input int pos,
                                            input longint cash, input longint mtm);
    script_row_t r;
    r = '0;
    r.price = price;
    r.typed = 1'b1;
    r.want.full = full;
    r.want.act = act;
    r.want.pos = HELD_W'(pos);
    r.want.cash = cash;
    r.want.mtm = mtm;
    return r;
  endfunction

  // Offers one price beat, idling at random first, and records the result it owes once
  // the beat is taken. Valid stays high on return so back-to-back beats need no gap.
  task automatic send_close(input logic [IN_W-1:0] price, input logic use_typed,
                            input trade_result_t typed_want);
    trade_result_t predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_close_price <= price;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_trade_day(price);
    expected_days.push_back(use_typed ? typed_want : predicted);
  endtask

  // Writes one register once every owed result has come back, so the block is idle.
  task automatic write_setting(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_days.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      REG_WINDOW_LENGTH: begin
        // A new length throws the window away; position and cash survive.
        window_reg = data[WLEN_W-1:0];
        foreach (diff_ring[i]) diff_ring[i] = 0;
        ring_ptr = 0;
        days_seen = 0;
        up_moves = 0;
        down_moves = 0;
      end
      REG_MAX_POSITION: max_pos_reg = data[POS_W-1:0];
      REG_OVERSOLD:     oversold_reg = data[LVL_W-1:0];
      REG_OVERBOUGHT:   overbought_reg = data[LVL_W-1:0];
      default: ;
    endcase
  endtask

  // The result side stalls at random, at the same rate the price side idles.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < gap_pct);
  end

  // Every result beat taken is matched against the oldest owed result, field by field.
  always @(posedge clk) begin
    trade_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_days.size() == 0) begin
        $error("result beat arrived with no result owed");
        mismatch_count++;
      end else begin
        want = expected_days.pop_front();
        if (out_window_full !== want.full) begin
          $error("window_full: expected %0d, got %0d", want.full, out_window_full);
          mismatch_count++;
        end
        if (out_action !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, out_action);
          mismatch_count++;
        end
        if (out_position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, out_position);
          mismatch_count++;
        end
        if (out_cash_pnl !== want.cash) begin
          $error("cash_pnl: expected %0d, got %0d", want.cash, out_cash_pnl);
          mismatch_count++;
        end
        if (out_mark_to_market !== want.mtm) begin
          $error("mark_to_market: expected %0d, got %0d", want.mtm, out_mark_to_market);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [IN_W-1:0]       walk;
    logic [CFG_DATA_W-1:0] setting;
    int                    step;

    // Opening script. The first beats run under the reset settings and only warm up.
    // A window length of zero then acts as one, which makes every later result easy to
    // work out by hand: a flat day gives no movement and no trade, a rise alone is an
    // index of exactly 100, and a fall alone is an index of 0. After that come a zero
    // position limit, a sell level of exactly 100 percent, a buy level above 100
    // percent, and a limit lowered under the held position, where only the sell that
    // moves back toward the limit goes through. The tail runs an over-long window with
    // extreme price swings through the predictor.
    directed_script = '{
      typed_row(32'd0,          1'b0, ACT_NONE, 0, 0, 0),
      typed_row(32'hFFFF_FFFF,  1'b0, ACT_NONE, 0, 0, 0),
      write_row(REG_WINDOW_LENGTH, 0),
      typed_row(32'd100,        1'b0, ACT_NONE, 0, 0, 0),
      typed_row(32'd100,        1'b1, ACT_NONE, 0, 0, 0),
      typed_row(32'd300,        1'b1, ACT_SELL, -1, 300, 0),
      typed_row(32'd100,        1'b1, ACT_BUY,  0, 200, 200),
      typed_row(32'd100,        1'b1, ACT_NONE, 0, 200, 200),
      write_row(REG_MAX_POSITION, 0),
      typed_row(32'd50,         1'b1, ACT_NONE, 0, 200, 200),
      write_row(REG_MAX_POSITION, 1023),
      write_row(REG_OVERBOUGHT, 25600),
      typed_row(32'd60,         1'b1, ACT_NONE, 0, 200, 200),
      write_row(REG_OVERSOLD, 32767),
      typed_row(32'd70,         1'b1, ACT_BUY,  1, 130, 200),
      typed_row(32'd70,         1'b1, ACT_NONE, 1, 130, 200),
      typed_row(32'd80,         1'b1, ACT_BUY,  2, 50, 210),
      typed_row(32'd90,         1'b1, ACT_BUY,  3, -40, 230),
      write_row(REG_MAX_POSITION, 1),
      typed_row(32'd100,        1'b1, ACT_NONE, 3, -40, 260),
      write_row(REG_OVERBOUGHT, 0),
      typed_row(32'd110,        1'b1, ACT_SELL, 2, 70, 290),
      write_row(REG_WINDOW_LENGTH, 127),
      write_row(REG_OVERSOLD, 7680),
      write_row(REG_OVERBOUGHT, 17920),
      write_row(REG_MAX_POSITION, 1023),
      day_row(32'hFFFF_FFFF),
      day_row(32'd0),
      day_row(32'hFFFF_FFFF),
      day_row(32'd0),
      day_row(32'd7),
      day_row(32'h8000_0000),
      day_row(32'h7FFF_FFFF)
    };

    // Synchronous reset.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_script[i]) begin
      if (directed_script[i].is_write) begin
        write_setting(directed_script[i].reg_sel, directed_script[i].wdata);
      end else begin
        send_close(directed_script[i].price, directed_script[i].typed,
                   directed_script[i].want);
      end
    end

    // Random part: ten stretches of about a hundred beats, each under new settings.
    // Prices mostly wander a few hundred ticks per day so that the index swings through
    // both thresholds, with occasional jumps to zero, to full scale and to anywhere.
    // The window is left alone in some stretches, so the book and the window both carry
    // over into new limits. One stretch runs with no idling and no stalls at all.
    for (int phase = 0; phase < 10; phase++) begin
      gap_pct = (phase == 5) ? 0 : 27;
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: setting = 0;
          1: setting = 64;
          2: setting = 127;
          3: setting = CFG_DATA_W'($urandom);
          default: setting = CFG_DATA_W'($urandom_range(1, 16));
        endcase
        write_setting(REG_WINDOW_LENGTH, setting);
      end
      case ($urandom_range(0, 5))
        0: setting = 0;
        1: setting = 1023;
        2: setting = CFG_DATA_W'($urandom);
        default: setting = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      write_setting(REG_MAX_POSITION, setting);
      case ($urandom_range(0, 6))
        0: setting = 0;
        1: setting = 25600;
        2: setting = CFG_DATA_W'($urandom);
        default: setting = CFG_DATA_W'($urandom_range(2000, 12000));
      endcase
      write_setting(REG_OVERSOLD, setting);
      case ($urandom_range(0, 6))
        0: setting = 25600;
        1: setting = 0;
        2: setting = CFG_DATA_W'($urandom);
        default: setting = CFG_DATA_W'($urandom_range(13000, 24000));
      endcase
      write_setting(REG_OVERBOUGHT, setting);

      walk = ($urandom_range(0, 3) == 0) ? IN_W'($urandom) : IN_W'($urandom_range(100, 100000));
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 19))
          0: walk = IN_W'($urandom);
          1: walk = '0;
          2: walk = '1;
          default: begin
            step = int'($urandom_range(0, 2000)) - 1000;
            // Clamp the walk at the ends of the price range rather than wrapping.
            if (step < 0 && walk < IN_W'(-step)) walk = '0;
            else if (step > 0 && walk > 32'hFFFF_FFFF - IN_W'(step)) walk = '1;
            else walk = walk + IN_W'(step);
          end
        endcase
        send_close(walk, 1'b0, '0);
      end
    end

    // Drain: every owed result must come back, then a short quiet tail catches strays.
    in_valid <= 1'b0;
    while (expected_days.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
